[design/rms_noise_level_meter_assert.svh]
// ----------------------------------------------------------------------------
// RMS noise level meter assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RMS_NOISE_LEVEL_METER_ASSERT_SVH
`define RMS_NOISE_LEVEL_METER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMSM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rms meter check failed");

// Consequent must hold in the cycle after the antecedent.
`define RMSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rms meter check failed");

`endif

[design/rmsm_pkg.sv]
// ----------------------------------------------------------------------------
// RMS noise level meter package
// Types, widths and codes shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package rmsm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SQ_W      = 31;
    localparam int DIVD_W    = 40;
    localparam int DIVS_W    = 16;
    localparam int DCNT_W    = 6;
    localparam int MS_W      = 31;
    localparam int SQRT_W    = 24;
    localparam int RAD_W     = 48;
    localparam int SREM_W    = 26;
    localparam int SCNT_W    = 5;
    localparam int Q8_SHIFT  = 8;
    localparam int PCT_W     = 7;
    localparam int PCT_MAX   = 100;
    localparam int SCALED_W  = SQRT_W + PCT_W - Q8_SHIFT;
    localparam int LVL_Q8_W  = 15;
    localparam int FS_W      = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 1'b1;
    localparam logic [FS_W-1:0]      FS_RESET       = 15'd500;

    typedef enum logic [3:0] {
        S_ACC, S_MS_GO, S_MS_WAIT, S_SQ_GO, S_SQ_WAIT, S_MUL,
        S_PCT_GO, S_PCT_WAIT, S_EMA, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DSEL_MS, DSEL_PCT
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        t_div_sel div_sel;
        logic     sqrt_start;
        logic     mul_cap;
        logic     pct_cap;
        logic     step_cap;
        logic     upd;
    } t_cmd;

    typedef struct packed {
        logic end_pend;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_sts;

endpackage

[design/rms_noise_level_meter.sv]
// ----------------------------------------------------------------------------
// RMS noise level meter
// Chunked RMS loudness in percent of full scale with exponential smoothing.
// ----------------------------------------------------------------------------
// Signed 16-bit samples enter on the slave stream, one beat per cycle while
// a chunk is being gathered; each beat is squared and summed into a
// saturating 40-bit accumulator. A chunk closes at a beat with tlast set or
// at the beat that brings the count to MAX_CHUNK_SAMPLES. The block then
// stops taking beats while it forms the result: the mean square and the
// percent against full scale are two passes of one shared bit-serial
// divider, the Q8 square root is a digit-by-digit unit, and the
// smoothing step is a reciprocal multiplication; these set the
// chunk-end time. One result beat leaves per chunk through an
// output register, so a result waiting on the master side does not hold up
// the next chunk; only a second result finding the register still full adds
// wait cycles. The configuration port writes full_scale_rms (index 0, zero
// acts as one) and meter_enable (index 1); write it only while the meter is
// idle. With the meter disabled, smoothing runs as usual but noise_level
// reads as zero.
// ----------------------------------------------------------------------------
`include "rms_noise_level_meter_assert.svh"

module rms_noise_level_meter #(
    parameter int MAX_CHUNK_SAMPLES = 512,
    parameter int EMA_CHUNKS        = 96
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,   // last_of_chunk
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] noise_level, [13:7] instant_percent
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_wdata
);
    import rmsm_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [PCT_W-1:0] w_noise;
    logic [PCT_W-1:0] w_inst;

    rmsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rmsm_dpath #(
        .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES),
        .EMA_CHUNKS        (EMA_CHUNKS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_sample          ($signed(s_axis_tdata)),
        .i_last            (s_axis_tlast),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_noise_level     (w_noise),
        .o_instant_percent (w_inst)
    );

    assign m_axis_tdata = {2'b00, w_inst, w_noise};

    // A beat taken now cannot produce a result in the very next cycle.
    `RMSM_ASSERT_NEXT(a_no_result_after_beat, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))
    // The divider is never restarted while samples are still being taken.
    `RMSM_ASSERT_SAME(a_busy_blocks_input, i_clk, i_rst_n, w_cmd.div_start, !s_axis_tready)
    // Both reported levels stay within percent range.
    `RMSM_ASSERT_SAME(a_level_range, i_clk, i_rst_n, m_axis_tvalid, (w_noise <= 7'd100) && (w_inst <= 7'd100))

endmodule

[design/rmsm_div.sv]
// ----------------------------------------------------------------------------
// RMS meter serial divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmsm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rmsm_pkg::DIVD_W-1:0] i_dividend,
    input  logic [rmsm_pkg::DIVS_W-1:0] i_divisor,
    output logic [rmsm_pkg::DIVD_W-1:0] o_quotient,
    output logic                        o_done
);
    import rmsm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [DIVS_W:0]   w_trial;
    logic [DIVS_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVS_W-1:0] : w_trial[DIVS_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

[design/rmsm_isqrt.sv]
// ----------------------------------------------------------------------------
// RMS meter integer square root
// Digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rmsm_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rmsm_pkg::RAD_W-1:0] i_radicand,
    output logic [rmsm_pkg::SQRT_W-1:0] o_root,
    output logic                       o_done
);
    import rmsm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [SCNT_W-1:0] r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [SREM_W-1:0] r_rem;
    logic [SQRT_W-1:0] r_root;
    logic [SREM_W+1:0] w_acc;
    logic [SREM_W+1:0] w_trial;
    logic [SREM_W+1:0] w_diff;
    logic              w_ge;

    // Bring down the next two radicand bits and try root*4 + 1.
    assign w_acc   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_acc >= w_trial);
    assign w_diff  = w_acc - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SCNT_W'(SQRT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[SREM_W-1:0] : w_acc[SREM_W-1:0];
            r_root <= {r_root[SQRT_W-2:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

[design/rmsm_ctrl.sv]
// ----------------------------------------------------------------------------
// RMS meter controller
// Sequences accumulation and the end-of-chunk computation steps.
// ----------------------------------------------------------------------------
module rmsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rmsm_pkg::t_sts i_sts,
    output rmsm_pkg::t_cmd o_cmd
);
    import rmsm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_in_ready   = !i_sts.end_pend;
                o_cmd.accept = i_in_valid && !i_sts.end_pend;
                if (i_sts.end_pend) begin
                    n_state = S_MS_GO;
                end
            end
            S_MS_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_MS;
                n_state         = S_MS_WAIT;
            end
            S_MS_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_SQ_GO;
                end
            end
            S_SQ_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_cap = 1'b1;
                n_state       = S_PCT_GO;
            end
            S_PCT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_PCT;
                n_state         = S_PCT_WAIT;
            end
            S_PCT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.pct_cap = 1'b1;
                    n_state       = S_EMA;
                end
            end
            S_EMA: begin
                o_cmd.step_cap = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

endmodule

[design/rmsm_dpath.sv]
// ----------------------------------------------------------------------------
// RMS meter datapath
// Square accumulator, shared divider, square root, scaling and smoothing.
// ----------------------------------------------------------------------------
module rmsm_dpath #(
    parameter int MAX_CHUNK_SAMPLES = 512,
    parameter int EMA_CHUNKS        = 96
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rmsm_pkg::t_cmd                       i_cmd,
    output rmsm_pkg::t_sts                       o_sts,
    input  logic signed [rmsm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last,
    input  logic                                 i_cfg_we,
    input  logic [rmsm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rmsm_pkg::FS_W-1:0]            i_cfg_wdata,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [rmsm_pkg::PCT_W-1:0]           o_noise_level,
    output logic [rmsm_pkg::PCT_W-1:0]           o_instant_percent
);
    import rmsm_pkg::*;

    localparam int CW = $clog2(MAX_CHUNK_SAMPLES + 1);

    // Reciprocal of EMA_CHUNKS, rounded up, scaled so that the product
    // shifted down gives the exact floor quotient of any 15-bit magnitude.
    localparam int              EMA_SH  = LVL_Q8_W + $clog2(EMA_CHUNKS);
    localparam longint unsigned EMA_RCP = ((64'd1 << EMA_SH) + 64'(EMA_CHUNKS) - 64'd1)
                                          / 64'(EMA_CHUNKS);
    localparam int              RCP_W   = LVL_Q8_W + 2;
    localparam int              PROD_W  = LVL_Q8_W + RCP_W;

    logic [FS_W-1:0]          r_fs;
    logic                     r_en;
    logic [SQ_W-1:0]          r_sq;
    logic                     r_sq_vld;
    logic                     r_end_pend;
    logic [DIVD_W-1:0]        r_sum;
    logic [CW-1:0]            r_cnt;
    logic [SCALED_W-1:0]      r_scaled;
    logic [PCT_W-1:0]         r_pct;
    logic [LVL_Q8_W-1:0]      r_step;
    logic [LVL_Q8_W-1:0]      r_smooth;
    logic                     r_out_vld;
    logic [PCT_W-1:0]         r_out_noise;
    logic [PCT_W-1:0]         r_out_inst;

    logic [SAMPLE_W-1:0]      w_mag;
    logic [2*SAMPLE_W-1:0]    w_sq;
    logic [CW-1:0]            w_cnt_next;
    logic                     w_full;
    logic [DIVD_W:0]          w_sum_ext;
    logic [DIVD_W-1:0]        w_dividend;
    logic [DIVS_W-1:0]        w_divisor;
    logic [DIVS_W-1:0]        w_fs_nz;
    logic [DIVD_W-1:0]        w_quo;
    logic                     w_div_done;
    logic [SQRT_W-1:0]        w_root;
    logic                     w_sqrt_done;
    logic [SQRT_W+PCT_W-1:0]  w_prod;
    logic [LVL_Q8_W-1:0]      w_target;
    logic                     w_neg;
    logic [LVL_Q8_W-1:0]      w_diff;
    logic [PROD_W-1:0]        w_step_prod;
    logic [LVL_Q8_W-1:0]      w_step;
    logic [LVL_Q8_W-1:0]      w_smooth_next;
    logic                     w_out_free;

    assign w_mag      = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;
    assign w_sq       = w_mag * w_mag;
    assign w_cnt_next = r_cnt + 1'b1;
    assign w_full     = (w_cnt_next == CW'(MAX_CHUNK_SAMPLES));
    assign w_sum_ext  = (DIVD_W+1)'(r_sum) + (DIVD_W+1)'(r_sq);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= FS_RESET;
            r_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FULL_SCALE: r_fs <= i_cfg_wdata;
                CFG_ENABLE:     r_en <= i_cfg_wdata[0];
                default:        r_en <= r_en;
            endcase
        end
    end

    // Accumulator: square registered on accept, added the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld   <= 1'b0;
            r_end_pend <= 1'b0;
            r_sum      <= '0;
            r_cnt      <= '0;
        end else begin
            r_sq_vld <= i_cmd.accept;
            if (r_sq_vld) begin
                r_sum <= w_sum_ext[DIVD_W] ? '1 : w_sum_ext[DIVD_W-1:0];
            end
            if (i_cmd.accept) begin
                r_cnt      <= w_cnt_next;
                r_end_pend <= i_last || w_full;
            end
            if (i_cmd.div_start && (i_cmd.div_sel == DSEL_MS)) begin
                r_sum      <= '0;
                r_cnt      <= '0;
                r_end_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sq <= w_sq[SQ_W-1:0];
        end
    end

    // Shared divider operand selection.
    assign w_fs_nz  = (r_fs == '0) ? DIVS_W'(1) : DIVS_W'(r_fs);
    assign w_target = {r_pct, Q8_SHIFT'(0)};
    assign w_neg    = (w_target < r_smooth);
    assign w_diff   = w_neg ? (r_smooth - w_target) : (w_target - r_smooth);

    always_comb begin
        unique case (i_cmd.div_sel)
            DSEL_MS: begin
                w_dividend = r_sum;
                w_divisor  = DIVS_W'(r_cnt);
            end
            DSEL_PCT: begin
                w_dividend = DIVD_W'(r_scaled);
                w_divisor  = w_fs_nz;
            end
            default: begin
                w_dividend = r_sum;
                w_divisor  = w_fs_nz;
            end
        endcase
    end

    rmsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // Mean square in Q16 gives the root directly in Q8.
    rmsm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (RAD_W'({w_quo[MS_W-1:0], 16'h0000})),
        .o_root     (w_root),
        .o_done     (w_sqrt_done)
    );

    assign w_prod      = w_root * (SQRT_W+PCT_W)'(PCT_MAX);
    assign w_step_prod = PROD_W'(w_diff) * PROD_W'(EMA_RCP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_cap) begin
            r_scaled <= w_prod[SQRT_W+PCT_W-1:Q8_SHIFT];
        end
        if (i_cmd.pct_cap) begin
            r_pct <= (w_quo > DIVD_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : w_quo[PCT_W-1:0];
        end
        if (i_cmd.step_cap) begin
            r_step <= LVL_Q8_W'(w_step_prod >> EMA_SH);
        end
    end

    // Smoothing step: the magnitude quotient truncates toward zero.
    assign w_step        = r_step;
    assign w_smooth_next = w_neg ? (r_smooth - w_step) : (r_smooth + w_step);
    assign w_out_free    = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.upd) begin
                r_smooth  <= w_smooth_next;
                r_out_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out_noise <= r_en ? w_smooth_next[LVL_Q8_W-1:Q8_SHIFT] : '0;
            r_out_inst  <= r_pct;
        end
    end

    assign o_sts.end_pend  = r_end_pend;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.sqrt_done = w_sqrt_done;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid       = r_out_vld;
    assign o_noise_level     = r_out_noise;
    assign o_instant_percent = r_out_inst;

endmodule
